### design/npps_pkg.sv
`timescale 1ns / 1ps

package npps_pkg;

    localparam int unsigned MAX_TASKS_DEF      = 16;
    localparam int unsigned TIME_WIDTH_DEF     = 16;
    localparam int unsigned PRIORITY_WIDTH_DEF = 8;

    typedef enum logic [2:0] {
        ST_EMPTY    = 3'd0,
        ST_WAITING  = 3'd1,
        ST_READY    = 3'd2,
        ST_RUNNING  = 3'd3,
        ST_FINISHED = 3'd4
    } npps_status_t;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } npps_cmd_t;

    typedef struct packed {
        logic rd_en;
        logic load_we;
        logic stat_we;
    } npps_tbl_ctl_t;

endpackage

### design/npps_table.sv
`timescale 1ns / 1ps

module npps_table import npps_pkg::*; #(
    parameter int unsigned MAX_TASKS      = MAX_TASKS_DEF,
    parameter int unsigned TIME_WIDTH     = TIME_WIDTH_DEF,
    parameter int unsigned PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  npps_tbl_ctl_t             ctl,
    input  logic [$clog2(MAX_TASKS)-1:0] rd_addr,
    input  logic [$clog2(MAX_TASKS)-1:0] wr_addr,
    input  npps_status_t              wr_status,
    input  logic [TIME_WIDTH-1:0]     ld_arrival,
    input  logic [TIME_WIDTH-1:0]     ld_burst,
    input  logic [PRIORITY_WIDTH-1:0] ld_priority,
    output npps_status_t              rd_status,
    output logic [TIME_WIDTH-1:0]     rd_arrival,
    output logic [TIME_WIDTH-1:0]     rd_burst,
    output logic [PRIORITY_WIDTH-1:0] rd_priority
);

    localparam int unsigned DW = 2 * TIME_WIDTH + PRIORITY_WIDTH;

    npps_status_t        stat_mem [MAX_TASKS];
    logic [DW-1:0]       data_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] valid_reg;

    npps_status_t        stat_q;
    logic                vld_q;
    logic [DW-1:0]       data_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.load_we) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        priority if (ctl.load_we) begin
            stat_mem[wr_addr] <= ST_WAITING;
            data_mem[wr_addr] <= {ld_priority, ld_burst, ld_arrival};
        end else if (ctl.stat_we) begin
            stat_mem[wr_addr] <= wr_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            stat_q <= stat_mem[rd_addr];
            vld_q  <= valid_reg[rd_addr];
            data_q <= data_mem[rd_addr];
        end
    end

    assign rd_status   = vld_q ? stat_q : ST_EMPTY;
    assign rd_arrival  = data_q[TIME_WIDTH-1:0];
    assign rd_burst    = data_q[2*TIME_WIDTH-1:TIME_WIDTH];
    assign rd_priority = data_q[DW-1:2*TIME_WIDTH];

    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.load_we && ctl.stat_we))
        else $error("Load and status write collide in the task table.");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load_we |=> valid_reg[$past(wr_addr)])
        else $error("A loaded slot is not marked valid.");

endmodule

### design/nonpreemptive_priority_scheduler_top.sv
`timescale 1ns / 1ps
// Non-preemptive priority scheduler over a table of task slots.
// Requests arrive on the s_ channel: s_tuser selects a load (0) or a tick (1);
// a load fills one slot (arrival time, burst length, priority) unless it runs.
// Each tick request produces one result on the m_ channel giving the tick, the
// slot that ran, whether it was dispatched or finished, end time, turnaround
// and whether all loaded tasks are done. Loads produce no result.
// A load request is written straight into the table. A tick request occupies
// the block for a scan state, a drain state and a commit state: the scan reads
// one task entry per cycle from the task memory, promoting arrived tasks and
// picking the highest-priority ready slot when no task runs, then the commit
// state writes the result into the output register.
// The block accepts the next request while a result waits in the output
// register; a tick only stalls in its commit cycle if that register is
// still occupied because the receiver holds m_tready low.
// Reset (aresetn low, synchronous) empties every slot through per-slot valid
// bits, clears the time counter and the running task; no clearing pass runs.
module nonpreemptive_priority_scheduler_top import npps_pkg::*; #(
    parameter int unsigned MAX_TASKS      = MAX_TASKS_DEF,
    parameter int unsigned TIME_WIDTH     = TIME_WIDTH_DEF,
    parameter int unsigned PRIORITY_WIDTH = PRIORITY_WIDTH_DEF,
    localparam int unsigned SW        = $clog2(MAX_TASKS),
    localparam int unsigned IN_BITS   = SW + 2 * TIME_WIDTH + PRIORITY_WIDTH,
    localparam int unsigned S_TDATA_W = ((IN_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_BITS  = 3 * TIME_WIDTH + SW + 4,
    localparam int unsigned M_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // slot, arrival_time, burst_length, priority_level
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // time_slot, running_valid, running_slot, dispatched, finished,
    // end_time, turnaround, all_done
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned CW = $clog2(MAX_TASKS + 1);
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FINAL = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [TIME_WIDTH-1:0]     now_tick_reg, now_tick_next;
    logic                      busy_reg, busy_next;
    logic [SW-1:0]             active_reg, active_next;
    logic [TIME_WIDTH-1:0]     ticks_left_reg, ticks_left_next;
    logic [TIME_WIDTH-1:0]     active_arr_reg, active_arr_next;

    logic [SW-1:0]             rd_idx_reg, rd_idx_next;
    logic                      pv_reg;
    logic [SW-1:0]             pidx_reg;

    logic                      found_reg, found_next;
    logic [SW-1:0]             best_idx_reg, best_idx_next;
    logic [PRIORITY_WIDTH-1:0] best_prio_reg, best_prio_next;
    logic [TIME_WIDTH-1:0]     best_burst_reg, best_burst_next;
    logic [TIME_WIDTH-1:0]     best_arr_reg, best_arr_next;
    logic [CW-1:0]             pend_cnt_reg, pend_cnt_next;

    logic                      m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]      m_tdata_reg, m_tdata_next;

    npps_tbl_ctl_t             tbl_ctl;
    logic [SW-1:0]             tbl_wr_addr;
    npps_status_t              tbl_wr_status;
    npps_status_t              rd_status;
    logic [TIME_WIDTH-1:0]     rd_arrival;
    logic [TIME_WIDTH-1:0]     rd_burst;
    logic [PRIORITY_WIDTH-1:0] rd_priority;

    logic                      in_fire;
    npps_cmd_t                 in_cmd;
    logic [SW-1:0]             in_slot;
    logic [TIME_WIDTH-1:0]     in_arrival;
    logic [TIME_WIDTH-1:0]     in_burst;
    logic [TIME_WIDTH-1:0]     ld_burst;
    logic [PRIORITY_WIDTH-1:0] in_prio;
    logic                      load_ok;

    logic                      promote;
    logic                      now_ready;
    logic                      pending;
    logic                      take;

    logic                      final_fire;
    logic                      run;
    logic                      disp;
    logic                      fin;
    logic [SW-1:0]             run_slot;
    logic [TIME_WIDTH-1:0]     left0;
    logic [TIME_WIDTH-1:0]     left1;
    logic [TIME_WIDTH-1:0]     run_arr;
    logic [TIME_WIDTH-1:0]     end_t;
    logic [TIME_WIDTH-1:0]     turn;
    logic                      done;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_cmd   = npps_cmd_t'(s_tuser);
    assign in_slot    = s_tdata[SW-1:0];
    assign in_arrival = s_tdata[SW+TIME_WIDTH-1:SW];
    assign in_burst   = s_tdata[SW+2*TIME_WIDTH-1:SW+TIME_WIDTH];
    assign in_prio    = s_tdata[IN_BITS-1:SW+2*TIME_WIDTH];
    assign ld_burst   = (in_burst == '0) ? TIME_WIDTH'(1) : in_burst;
    assign load_ok    = ({1'b0, in_slot} < (SW + 1)'(MAX_TASKS))
                     && !(busy_reg && (in_slot == active_reg));

    assign promote   = pv_reg && (rd_status == ST_WAITING) && (rd_arrival <= now_tick_reg);
    assign now_ready = pv_reg && ((rd_status == ST_READY) || promote);
    assign pending   = pv_reg && ((rd_status == ST_WAITING) || (rd_status == ST_READY)
                                  || (rd_status == ST_RUNNING));
    assign take      = now_ready && !busy_reg
                    && (!found_reg || (rd_priority > best_prio_reg));

    assign final_fire = (state_reg == S_FINAL) && !(m_valid_reg && !m_tready);
    assign disp     = !busy_reg && found_reg;
    assign run      = busy_reg || found_reg;
    assign run_slot = busy_reg ? active_reg : best_idx_reg;
    assign left0    = busy_reg ? ticks_left_reg : best_burst_reg;
    assign left1    = (left0 != '0) ? left0 - TIME_WIDTH'(1) : '0;
    assign fin      = run && (left1 == '0);
    assign run_arr  = busy_reg ? active_arr_reg : best_arr_reg;
    assign end_t    = (now_tick_reg < TIME_MAX) ? now_tick_reg + TIME_WIDTH'(1) : TIME_MAX;
    assign turn     = (end_t >= run_arr) ? end_t - run_arr : '0;
    assign done     = (pend_cnt_reg == '0) || ((pend_cnt_reg == CW'(1)) && fin);

    always_comb begin
        tbl_ctl.rd_en   = (state_reg == S_SCAN);
        tbl_ctl.load_we = in_fire && (in_cmd == CMD_LOAD) && load_ok;
        tbl_ctl.stat_we = 1'b0;
        tbl_wr_addr     = in_slot;
        tbl_wr_status   = ST_READY;
        unique case (state_reg)
            S_IDLE: begin
                tbl_wr_addr = in_slot;
            end
            S_SCAN, S_DRAIN: begin
                tbl_ctl.stat_we = promote;
                tbl_wr_addr     = pidx_reg;
            end
            S_FINAL: begin
                tbl_ctl.stat_we = final_fire && run;
                tbl_wr_addr     = run_slot;
                tbl_wr_status   = fin ? ST_FINISHED : ST_RUNNING;
            end
            default: begin
                tbl_wr_addr = in_slot;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        now_tick_next   = now_tick_reg;
        busy_next       = busy_reg;
        active_next     = active_reg;
        ticks_left_next = ticks_left_reg;
        active_arr_next = active_arr_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_burst_next = best_burst_reg;
        best_arr_next   = best_arr_reg;
        pend_cnt_next   = pend_cnt_reg;
        m_tdata_next    = m_tdata_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        if (take) begin
            found_next      = 1'b1;
            best_idx_next   = pidx_reg;
            best_prio_next  = rd_priority;
            best_burst_next = rd_burst;
            best_arr_next   = rd_arrival;
        end
        if (pending) begin
            pend_cnt_next = pend_cnt_reg + CW'(1);
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire && (in_cmd == CMD_TICK)) begin
                    state_next    = S_SCAN;
                    rd_idx_next   = '0;
                    found_next    = 1'b0;
                    pend_cnt_next = '0;
                end
            end
            S_SCAN: begin
                rd_idx_next = rd_idx_reg + SW'(1);
                if (rd_idx_reg == SW'(MAX_TASKS - 1)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_FINAL;
            end
            S_FINAL: begin
                if (final_fire) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    if (run) begin
                        busy_next       = !fin;
                        active_next     = run_slot;
                        ticks_left_next = left1;
                        active_arr_next = run_arr;
                    end
                    if (now_tick_reg < TIME_MAX) begin
                        now_tick_next = now_tick_reg + TIME_WIDTH'(1);
                    end
                    m_tdata_next = '0;
                    m_tdata_next[OUT_BITS-1:0] = {
                        done,
                        fin ? turn : {TIME_WIDTH{1'b0}},
                        fin ? end_t : {TIME_WIDTH{1'b0}},
                        fin,
                        disp,
                        run ? run_slot : {SW{1'b0}},
                        run,
                        now_tick_reg
                    };
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            now_tick_reg   <= '0;
            busy_reg       <= 1'b0;
            active_reg     <= '0;
            ticks_left_reg <= '0;
            rd_idx_reg     <= '0;
            pv_reg         <= 1'b0;
            found_reg      <= 1'b0;
            pend_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            now_tick_reg   <= now_tick_next;
            busy_reg       <= busy_next;
            active_reg     <= active_next;
            ticks_left_reg <= ticks_left_next;
            rd_idx_reg     <= rd_idx_next;
            pv_reg         <= (state_reg == S_SCAN);
            found_reg      <= found_next;
            pend_cnt_reg   <= pend_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg       <= rd_idx_reg;
        active_arr_reg <= active_arr_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_burst_reg <= best_burst_next;
        best_arr_reg   <= best_arr_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    npps_table #(
        .MAX_TASKS      (MAX_TASKS),
        .TIME_WIDTH     (TIME_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (tbl_ctl),
        .rd_addr     (rd_idx_reg),
        .wr_addr     (tbl_wr_addr),
        .wr_status   (tbl_wr_status),
        .ld_arrival  (in_arrival),
        .ld_burst    (ld_burst),
        .ld_priority (in_prio),
        .rd_status   (rd_status),
        .rd_arrival  (rd_arrival),
        .rd_burst    (rd_burst),
        .rd_priority (rd_priority)
    );

    a_busy_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (ticks_left_reg != '0))
        else $error("A running task has no ticks left.");

    a_commit_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        final_fire |=> m_valid_reg)
        else $error("A committed tick did not produce a result.");

    a_time_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (now_tick_reg >= $past(now_tick_reg)))
        else $error("The time counter moved backward.");

endmodule

### test/scheduler_checker.sv
`timescale 1ns / 1ps

module scheduler_checker import npps_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          fail_count,
    output int          pending_count,
    output int          finish_count
);

    localparam int SLOTS = MAX_TASKS_DEF;
    localparam logic [15:0] TIME_MAX = 16'hFFFF;

    typedef struct packed {
        logic        all_done;
        logic [15:0] turnaround;
        logic [15:0] end_time;
        logic        finished;
        logic        dispatched;
        logic [3:0]  running_slot;
        logic        running_valid;
        logic [15:0] time_slot;
    } tick_report_t;

    tick_report_t reports[$];

    npps_status_t task_state   [SLOTS];
    logic [15:0]  task_arrival [SLOTS];
    logic [15:0]  task_burst   [SLOTS];
    logic [7:0]   task_prio    [SLOTS];
    logic [15:0]  sched_now;
    logic [15:0]  burst_left;
    logic         cpu_busy;
    logic [3:0]   running_idx;

    tick_report_t want;
    tick_report_t got;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        finish_count  = 0;
    end

    task automatic clear_schedule();
        for (int i = 0; i < SLOTS; i++) begin
            task_state[i]   = ST_EMPTY;
            task_arrival[i] = '0;
            task_burst[i]   = '0;
            task_prio[i]    = '0;
        end
        sched_now   = '0;
        burst_left  = '0;
        cpu_busy    = 1'b0;
        running_idx = '0;
        reports.delete();
    endtask

    task automatic store_task(input logic [3:0] slot, input logic [15:0] arrival,
                              input logic [15:0] burst, input logic [7:0] prio);
        if (cpu_busy && slot == running_idx) begin
            return;
        end
        task_state[slot]   = ST_WAITING;
        task_arrival[slot] = arrival;
        task_burst[slot]   = (burst == 16'd0) ? 16'd1 : burst;
        task_prio[slot]    = prio;
    endtask

    task automatic run_one_tick(output tick_report_t r);
        int          best;
        bit          found;
        logic [15:0] fin_time;
        r = '0;
        r.time_slot = sched_now;
        for (int i = 0; i < SLOTS; i++) begin
            if (task_state[i] == ST_WAITING && task_arrival[i] <= sched_now) begin
                task_state[i] = ST_READY;
            end
        end
        if (!cpu_busy) begin
            found = 1'b0;
            best  = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (task_state[i] == ST_READY && (!found || task_prio[i] > task_prio[best])) begin
                    best  = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                cpu_busy         = 1'b1;
                running_idx      = best[3:0];
                burst_left       = task_burst[best];
                task_state[best] = ST_RUNNING;
                r.dispatched     = 1'b1;
            end
        end
        if (cpu_busy) begin
            r.running_valid = 1'b1;
            r.running_slot  = running_idx;
            if (burst_left != 16'd0) begin
                burst_left = burst_left - 16'd1;
            end
            if (burst_left == 16'd0) begin
                fin_time     = (sched_now != TIME_MAX) ? sched_now + 16'd1 : TIME_MAX;
                r.finished   = 1'b1;
                r.end_time   = fin_time;
                r.turnaround = (fin_time >= task_arrival[running_idx]) ?
                               fin_time - task_arrival[running_idx] : 16'd0;
                task_state[running_idx] = ST_FINISHED;
                cpu_busy = 1'b0;
            end
        end
        r.all_done = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
            if (task_state[i] == ST_WAITING || task_state[i] == ST_READY ||
                task_state[i] == ST_RUNNING) begin
                r.all_done = 1'b0;
            end
        end
        if (sched_now != TIME_MAX) begin
            sched_now = sched_now + 16'd1;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] expected,
                               input logic [15:0] actual);
        if (actual !== expected) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_schedule();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (got.finished === 1'b1) begin
                    finish_count++;
                end
                if (reports.size() == 0) begin
                    $error("Result for time %0d arrived with no tick request pending",
                           got.time_slot);
                    fail_count++;
                end else begin
                    want = reports.pop_front();
                    check_field("time_slot", want.time_slot, got.time_slot);
                    check_field("running_valid", want.running_valid, got.running_valid);
                    check_field("running_slot", want.running_slot, got.running_slot);
                    check_field("dispatched", want.dispatched, got.dispatched);
                    check_field("finished", want.finished, got.finished);
                    check_field("end_time", want.end_time, got.end_time);
                    check_field("turnaround", want.turnaround, got.turnaround);
                    check_field("all_done", want.all_done, got.all_done);
                end
            end
            if (s_tvalid && s_tready) begin
                if (npps_cmd_t'(s_tuser) == CMD_TICK) begin
                    run_one_tick(want);
                    reports = {reports, want};
                end else begin
                    store_task(s_tdata[3:0], s_tdata[19:4], s_tdata[35:20], s_tdata[43:36]);
                end
            end
        end
        pending_count = reports.size();
    end

endmodule

### test/tb_nonpreemptive_priority_scheduler_top.sv
`timescale 1ns / 1ps

module tb_nonpreemptive_priority_scheduler_top;
    import npps_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int RANDOM_REQUESTS = 410;
    localparam int TAIL_TICKS = 16;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    int fail_count;
    int pending_count;
    int finish_count;
    int cycle_count = 0;
    int loads_sent = 0;
    int ticks_sent = 0;
    int now_est = 0;
    bit calm = 1'b0;

    nonpreemptive_priority_scheduler_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    scheduler_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .finish_count  (finish_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 29);
    end

    // The request stays on the bus until accepted; unless calm, idle cycles may precede it.
    task automatic send_request(input npps_cmd_t cmd, input logic [3:0] slot,
                                input logic [15:0] arrival, input logic [15:0] burst,
                                input logic [7:0] prio);
        while (!calm && $urandom_range(0, 99) < 29) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, prio, burst, arrival, slot};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic load_task(input logic [3:0] slot, input logic [15:0] arrival,
                             input logic [15:0] burst, input logic [7:0] prio);
        send_request(CMD_LOAD, slot, arrival, burst, prio);
        loads_sent++;
    endtask

    task automatic tick_once();
        send_request(CMD_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        ticks_sent++;
        now_est++;
    endtask

    initial begin
        logic [3:0]  slot;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        int          pick;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_LOAD;
        m_tready = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // An empty table ticks idle, then a far-future task waits through the next tick.
        tick_once();
        load_task(4'd15, 16'hFFFF, 16'hFFFF, 8'hFF);
        tick_once();
        // The waiting slot is reloaded, with a zero burst that counts as one tick.
        load_task(4'd15, 16'd0, 16'd0, 8'd0);
        load_task(4'd0, 16'd0, 16'd3, 8'h80);
        load_task(4'd1, 16'd0, 16'd2, 8'h80);
        load_task(4'd2, 16'd3, 16'd1, 8'hFF);
        tick_once();
        // Slot 0 is running now, so this load must be dropped.
        load_task(4'd0, 16'd0, 16'd1, 8'd0);
        repeat (3) tick_once();
        // Slot 2 has finished; reloading it makes it wait again.
        load_task(4'd2, 16'd9, 16'd2, 8'h7F);
        load_task(4'd3, 16'd0, 16'd1, 8'h7F);
        repeat (8) tick_once();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            calm = (n >= 200 && n < 300);
            if ($urandom_range(0, 99) < 40) begin
                slot = 4'($urandom_range(0, 13));
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    arrival = 16'($urandom);
                end else if (pick < 13) begin
                    arrival = 16'($urandom_range(0, now_est));
                end else begin
                    arrival = 16'(now_est + $urandom_range(0, 20));
                end
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    burst = 16'd0;
                end else if (pick < 85) begin
                    burst = 16'($urandom_range(1, 6));
                end else begin
                    burst = 16'($urandom_range(7, 31));
                end
                prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                load_task(slot, arrival, burst, prio);
            end else begin
                tick_once();
            end
        end
        calm = 1'b0;

        // A maximal burst keeps slot 15 running; slot 14 only arrives at the top of time.
        load_task(4'd15, 16'(now_est), 16'hFFFF, 8'hF0);
        load_task(4'd14, 16'hFFFF, 16'd2, 8'h01);
        repeat (TAIL_TICKS) tick_once();
        s_tvalid <= 1'b0;

        while (pending_count != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);

        $display("Sent %0d loads and %0d ticks; %0d tasks finished.",
                 loads_sent, ticks_sent, finish_count);
        $display("Covered ties, dropped and repeated loads, zero bursts and long bursts.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
